// ===== rtl/pfa_pkg.sv =====
// shared types and constants for the fixed partition fit allocator
`timescale 1ns / 1ps

package pfa_pkg;

  // default sizing
  localparam int PartitionsDef = 16;
  localparam int SizeBitsDef   = 16;

  // field widths
  localparam int OpW       = 2;
  localparam int PartIdxW  = 4;
  localparam int SizeValW  = 16;
  localparam int ReqIdW    = 8;
  localparam int CountW    = 5;
  localparam int ModeW     = 2;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 5;

  // request operation codes
  localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
  localparam logic [OpW-1:0] OP_ALLOC = 2'd1;
  localparam logic [OpW-1:0] OP_FREE  = 2'd2;

  // placement modes
  localparam logic [ModeW-1:0] FIT_FIRST = 2'd0;
  localparam logic [ModeW-1:0] FIT_BEST  = 2'd1;
  localparam logic [ModeW-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_PART_COUNT = 2'd1;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [PartIdxW-1:0] part_index;
    logic [SizeValW-1:0] size_value;
    logic [ReqIdW-1:0]   request_id;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [PartIdxW-1:0] granted_index;
    logic [ReqIdW-1:0]   owner_id;
  } out_item_t;

  // control group from the sequencer to the compare unit
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             have_pick;
    logic             part_free;
  } fit_ctrl_t;

endpackage

// ===== rtl/pfa_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pfa_fit_unit.sv =====
// shared compare and subtract unit that judges one candidate partition
`timescale 1ns / 1ps

module pfa_fit_unit #(
  parameter int SIZE_BITS = pfa_pkg::SizeBitsDef
) (
  input  logic [SIZE_BITS-1:0] part_size,
  input  logic [SIZE_BITS-1:0] want,
  input  logic [SIZE_BITS-1:0] pick_left,
  input  pfa_pkg::fit_ctrl_t   ctrl,
  output logic                 take,
  output logic [SIZE_BITS-1:0] left
);

  logic fits;

  always_comb begin
    fits = ctrl.part_free && (part_size >= want);
    left = part_size - want;
    case (ctrl.mode)
      pfa_pkg::FIT_BEST:  take = fits && (!ctrl.have_pick || (left < pick_left));
      pfa_pkg::FIT_WORST: take = fits && (!ctrl.have_pick || (left >= pick_left));
      default:            take = fits && !ctrl.have_pick;
    endcase
  end

endmodule

// ===== rtl/fixed_partition_fit_allocator_unit.sv =====
// top level of the fixed partition allocator: sequencer, busy flags and ports
`timescale 1ns / 1ps

// Fixed partition allocator. A load request writes one partition size into a
// small size ram, a free request clears every busy flag, and an allocate
// request scans the partitions in use (the lowest partition_count, capped at
// PARTITIONS and at 31) for a free one large enough, picking by fit_mode:
// first fit takes the lowest index, best fit the smallest leftover (ties low),
// worst fit the largest leftover (ties high); mode 3 acts as first fit. Load
// and free give no result. An allocate scans the partitions in use, one
// compare and subtract unit looking at one partition per cycle as the size
// ram streams them out; with none in use it goes straight to the no-fit
// result. Each allocate gives one result; with no fit it reports all zero and
// changes nothing. A finished result sits in an output register, so loads and
// frees are still taken while it waits; an allocate that finishes while the
// earlier result is still held keeps the request side stalled until that one
// is taken. The user is to write configuration only while idle; the block
// itself does not enforce it. cfg_ready is always high.

module fixed_partition_fit_allocator_unit #(
  parameter int PARTITIONS = pfa_pkg::PartitionsDef,
  parameter int SIZE_BITS  = pfa_pkg::SizeBitsDef
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pfa_pkg::in_item_t                  in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output pfa_pkg::out_item_t                 out_data,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfa_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [pfa_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int IdxW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CountW = pfa_pkg::CountW;
  // largest count that can matter, kept inside the count width
  localparam logic [CountW-1:0] CountCap =
    (PARTITIONS >= 31) ? 5'd31 : CountW'(PARTITIONS);

  // one-hot sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [pfa_pkg::ModeW-1:0] fit_mode;
  logic [CountW-1:0]         partition_count;

  // busy flag per partition
  logic [PARTITIONS-1:0] busy, busy_next;

  // scan state
  logic [CountW-1:0]    scan_idx, scan_idx_next;
  logic [CountW-1:0]    n_active;
  logic                 cmp_valid, cmp_valid_next;
  logic [IdxW-1:0]      cmp_idx, cmp_idx_next;
  logic                 have_pick, have_pick_next;
  logic [IdxW-1:0]      pick_idx, pick_idx_next;
  logic [SIZE_BITS-1:0] pick_left, pick_left_next;
  logic [SIZE_BITS-1:0] want, want_next;
  logic [pfa_pkg::ReqIdW-1:0] rid, rid_next;

  // output register
  logic               out_valid_next;
  pfa_pkg::out_item_t out_data_next;

  // size ram ports
  logic                 ram_wr_en;
  logic [IdxW-1:0]      ram_wr_addr;
  logic [SIZE_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [IdxW-1:0]      ram_rd_addr;
  logic [SIZE_BITS-1:0] ram_rd_data;

  // compare unit
  pfa_pkg::fit_ctrl_t   fit_ctrl;
  logic                 fit_take;
  logic [SIZE_BITS-1:0] fit_left;

  // widened copies for safe truncation at any parameter value
  logic [8:0]  load_idx_w;
  logic [8:0]  scan_idx_w;
  logic [8:0]  pick_idx_w;
  logic [31:0] size_w;
  logic        in_accept;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  assign n_active   = (partition_count > CountCap) ? CountCap : partition_count;
  assign load_idx_w = 9'(in_data.part_index);
  assign scan_idx_w = 9'(scan_idx);
  assign pick_idx_w = 9'(pick_idx);
  assign size_w     = 32'(in_data.size_value);

  // size ram: written by loads while idle, streamed out during a scan
  assign ram_wr_en   = in_accept && (in_data.op == pfa_pkg::OP_LOAD) &&
                       (load_idx_w < 9'(PARTITIONS));
  assign ram_wr_addr = load_idx_w[IdxW-1:0];
  assign ram_wr_data = size_w[SIZE_BITS-1:0];
  assign ram_rd_en   = (state == ST_SCAN) && (scan_idx < n_active);
  assign ram_rd_addr = scan_idx_w[IdxW-1:0];

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (PARTITIONS),
    .ADDR_W(IdxW)
  ) u_size_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // one candidate per cycle through the shared compare unit
  always_comb begin
    fit_ctrl.mode      = fit_mode;
    fit_ctrl.have_pick = have_pick;
    fit_ctrl.part_free = !busy[cmp_idx];
  end

  pfa_fit_unit #(
    .SIZE_BITS(SIZE_BITS)
  ) u_fit_unit (
    .part_size(ram_rd_data),
    .want     (want),
    .pick_left(pick_left),
    .ctrl     (fit_ctrl),
    .take     (fit_take),
    .left     (fit_left)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    busy_next      = busy;
    scan_idx_next  = scan_idx;
    cmp_valid_next = 1'b0;
    cmp_idx_next   = cmp_idx;
    have_pick_next = have_pick;
    pick_idx_next  = pick_idx;
    pick_left_next = pick_left;
    want_next      = want;
    rid_next       = rid;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data.op)
            pfa_pkg::OP_FREE: begin
              busy_next = '0;
            end
            pfa_pkg::OP_ALLOC: begin
              want_next      = size_w[SIZE_BITS-1:0];
              rid_next       = in_data.request_id;
              have_pick_next = 1'b0;
              scan_idx_next  = '0;
              // nothing in use: straight to the no-fit result
              state_next     = (n_active == '0) ? ST_DONE : ST_SCAN;
            end
            default: begin
              // loads go through the ram port, op 3 is dropped
            end
          endcase
        end
      end

      ST_SCAN: begin
        // judge the entry read last cycle
        if (cmp_valid && fit_take) begin
          have_pick_next = 1'b1;
          pick_idx_next  = cmp_idx;
          pick_left_next = fit_left;
        end
        if (scan_idx < n_active) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next   = scan_idx_w[IdxW-1:0];
          scan_idx_next  = scan_idx + 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          if (have_pick) begin
            busy_next[pick_idx]         = 1'b1;
            out_data_next.granted       = 1'b1;
            out_data_next.granted_index = pick_idx_w[pfa_pkg::PartIdxW-1:0];
            out_data_next.owner_id      = rid;
          end else begin
            out_data_next = '0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      busy            <= '0;
      cmp_valid       <= 1'b0;
      have_pick       <= 1'b0;
      out_valid       <= 1'b0;
      fit_mode        <= pfa_pkg::FIT_FIRST;
      partition_count <= '0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      cmp_valid <= cmp_valid_next;
      have_pick <= have_pick_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pfa_pkg::REG_FIT_MODE:   fit_mode        <= cfg_data[pfa_pkg::ModeW-1:0];
          pfa_pkg::REG_PART_COUNT: partition_count <= cfg_data[CountW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    cmp_idx   <= cmp_idx_next;
    pick_idx  <= pick_idx_next;
    pick_left <= pick_left_next;
    want      <= want_next;
    rid       <= rid_next;
    out_data  <= out_data_next;
  end

  // checks

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished allocation");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= n_active))
    else $error("scan ran past the partitions in use");

  a_no_fit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.granted) |->
      (out_data.granted_index == '0 && out_data.owner_id == '0))
    else $error("refused request carries index or owner");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !ram_wr_en)
    else $error("size written during an allocation");

endmodule
